// ===== sv/rsk_pkg.sv =====
// ----------------------------------------------------------------------------
// rsk_pkg
// Shared types and constants for the record stack with keyed extraction.
// ----------------------------------------------------------------------------
package rsk_pkg;

  // Number of record cells in the stack.
  localparam int STACK_DEPTH = 16;

  // Field widths.
  localparam int ID_W     = 31;
  localparam int AGE_W    = 8;
  localparam int NAME_W   = 32;
  localparam int LEFT_W   = 5;
  localparam int CNT_W    = $clog2(STACK_DEPTH + 1);

  // Operation codes.
  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_FIND = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the operation and search the cells
    logic apply;  // update the cells and register the result
  } cmd_t;

endpackage

// ===== sv/rsk_ctrl.sv =====
// ----------------------------------------------------------------------------
// rsk_ctrl
// Controller: sequences the load and apply steps of one operation and
// raises the result strobe.
// ----------------------------------------------------------------------------
module rsk_ctrl (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  output rsk_pkg::cmd_t cmd
);
  import rsk_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_t;

  state_t state;

  // An operation is taken only while idle; the apply step follows it.
  assign busy      = (state != S_IDLE);
  assign cmd.load  = start && (state == S_IDLE);
  assign cmd.apply = (state == S_APPLY);

  // State register and the registered result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == S_APPLY);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/rsk_dp.sv =====
// ----------------------------------------------------------------------------
// rsk_dp
// Datapath: a row of record cells with cell 0 on top. All cells compare
// against the key in parallel; push shifts the row down, pop and
// find-and-remove shift the cells at and under the picked one up.
// ----------------------------------------------------------------------------
module rsk_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  rsk_pkg::cmd_t              cmd,
  input  logic [1:0]                 opcode,
  input  logic [rsk_pkg::ID_W-1:0]   key_id,
  input  logic [rsk_pkg::AGE_W-1:0]  record_age,
  input  logic [rsk_pkg::NAME_W-1:0] record_name_ref,
  output logic [1:0]                 status,
  output logic [rsk_pkg::ID_W-1:0]   out_id,
  output logic [rsk_pkg::AGE_W-1:0]  out_age,
  output logic [rsk_pkg::NAME_W-1:0] out_name_ref,
  output logic [rsk_pkg::LEFT_W-1:0] entries_left
);
  import rsk_pkg::*;

  // Record cells and the fill count.
  logic [ID_W-1:0]   cell_id   [STACK_DEPTH];
  logic [AGE_W-1:0]  cell_age  [STACK_DEPTH];
  logic [NAME_W-1:0] cell_name [STACK_DEPTH];
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  fill_next;

  // Captured operation.
  op_t               op_q;
  logic [ID_W-1:0]   id_q;
  logic [AGE_W-1:0]  age_q;
  logic [NAME_W-1:0] name_q;
  logic [STACK_DEPTH-1:0] hit_oh;
  logic              hit;

  // Search and apply signals.
  logic [STACK_DEPTH-1:0] live;
  logic [STACK_DEPTH-1:0] match;
  logic [STACK_DEPTH-1:0] pick_oh;
  logic [STACK_DEPTH-1:0] shift_up;
  logic              do_push;
  logic              do_remove;
  status_t           status_next;
  logic [ID_W-1:0]   sel_id;
  logic [AGE_W-1:0]  sel_age;
  logic [NAME_W-1:0] sel_name;

  // Compare every occupied cell with the incoming key.
  always_comb begin
    for (int k = 0; k < STACK_DEPTH; k++) begin
      live[k]  = (CNT_W'(k) < fill);
      match[k] = live[k] && (cell_id[k] == key_id);
    end
  end

  // Capture the operation and the topmost match as a one-hot mask.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= op_t'(opcode);
      id_q   <= key_id;
      age_q  <= record_age;
      name_q <= record_name_ref;
      hit_oh <= match & (~match + 1'b1);
      hit    <= |match;
    end
  end

  // Decide the update and the result status.
  always_comb begin
    do_push     = 1'b0;
    do_remove   = 1'b0;
    pick_oh     = '0;
    status_next = ST_MISS;
    unique case (op_q)
      OP_PUSH: begin
        if (fill == CNT_W'(STACK_DEPTH)) begin
          status_next = ST_FULL;
        end else begin
          do_push     = 1'b1;
          status_next = ST_OK;
        end
      end
      OP_POP: begin
        if (fill != '0) begin
          do_remove   = 1'b1;
          pick_oh     = STACK_DEPTH'(1);
          status_next = ST_OK;
        end
      end
      OP_FIND: begin
        if (hit) begin
          do_remove   = 1'b1;
          pick_oh     = hit_oh;
          status_next = ST_OK;
        end
      end
      default: begin
        status_next = ST_MISS;
      end
    endcase
    // Cells at and below the picked one move up by one place.
    shift_up = ~(pick_oh - 1'b1);
  end

  // Read the picked record through an AND-OR of the cells.
  always_comb begin
    sel_id   = '0;
    sel_age  = '0;
    sel_name = '0;
    for (int k = 0; k < STACK_DEPTH; k++) begin
      sel_id   = sel_id   | (cell_id[k]   & {ID_W{pick_oh[k]}});
      sel_age  = sel_age  | (cell_age[k]  & {AGE_W{pick_oh[k]}});
      sel_name = sel_name | (cell_name[k] & {NAME_W{pick_oh[k]}});
    end
  end

  // Next fill count.
  always_comb begin
    fill_next = fill;
    if (do_push) begin
      fill_next = fill + 1'b1;
    end else if (do_remove) begin
      fill_next = fill - 1'b1;
    end
  end

  // Cell row: push shifts down, removal shifts up.
  for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.apply && do_push) begin
        if (k == 0) begin
          cell_id[k]   <= id_q;
          cell_age[k]  <= age_q;
          cell_name[k] <= name_q;
        end else begin
          cell_id[k]   <= cell_id[(k == 0) ? 0 : k - 1];
          cell_age[k]  <= cell_age[(k == 0) ? 0 : k - 1];
          cell_name[k] <= cell_name[(k == 0) ? 0 : k - 1];
        end
      end else if (cmd.apply && do_remove && shift_up[k]) begin
        if (k < STACK_DEPTH - 1) begin
          cell_id[k]   <= cell_id[(k < STACK_DEPTH - 1) ? k + 1 : k];
          cell_age[k]  <= cell_age[(k < STACK_DEPTH - 1) ? k + 1 : k];
          cell_name[k] <= cell_name[(k < STACK_DEPTH - 1) ? k + 1 : k];
        end
      end
    end
  end

  // Fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.apply) begin
      fill <= fill_next;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      status       <= status_next;
      out_id       <= do_remove ? sel_id   : '0;
      out_age      <= do_remove ? sel_age  : '0;
      out_name_ref <= do_remove ? sel_name : '0;
      entries_left <= LEFT_W'(fill_next);
    end
  end

endmodule

// ===== sv/record_stack_with_keyed_extract_unit.sv =====
// ----------------------------------------------------------------------------
// record_stack_with_keyed_extract_unit
// Bounded LIFO stack of records with push, pop and find-and-remove by id.
// Sequence: a start transfer moves the controller into its apply state, and
// the done strobe and the result fields are registered from that state.
// A new operation is not taken while busy; busy is high for the one apply
// cycle that follows each transfer, and a new transfer may coincide with done.
// Reset empties the stack and clears the strobe; results cannot be stalled.
// ----------------------------------------------------------------------------
module record_stack_with_keyed_extract_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 opcode,
  input  logic [rsk_pkg::ID_W-1:0]   key_id,
  input  logic [rsk_pkg::AGE_W-1:0]  record_age,
  input  logic [rsk_pkg::NAME_W-1:0] record_name_ref,
  output logic                       done,
  output logic [1:0]                 status,
  output logic [rsk_pkg::ID_W-1:0]   out_id,
  output logic [rsk_pkg::AGE_W-1:0]  out_age,
  output logic [rsk_pkg::NAME_W-1:0] out_name_ref,
  output logic [rsk_pkg::LEFT_W-1:0] entries_left
);
  import rsk_pkg::*;

  cmd_t cmd;

  // Operation sequencing.
  rsk_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // Record cells, search and result registers.
  rsk_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .opcode          (opcode),
    .key_id          (key_id),
    .record_age      (record_age),
    .record_name_ref (record_name_ref),
    .status          (status),
    .out_id          (out_id),
    .out_age         (out_age),
    .out_name_ref    (out_name_ref),
    .entries_left    (entries_left)
  );

endmodule

// ===== sv/rsk_check.sv =====
// ----------------------------------------------------------------------------
// rsk_check
// Port-level checks on the record stack: timing of the result strobe and
// consistency of the returned fields.
// ----------------------------------------------------------------------------
module rsk_check (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic [1:0]                 status,
  input logic [rsk_pkg::ID_W-1:0]   out_id,
  input logic [rsk_pkg::AGE_W-1:0]  out_age,
  input logic [rsk_pkg::NAME_W-1:0] out_name_ref,
  input logic [rsk_pkg::LEFT_W-1:0] entries_left
);
  import rsk_pkg::*;

  // Every transfer is followed by its result strobe after the apply step.
  a_done_timing: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("result strobe missing two cycles after a transfer");

  // The block is busy for exactly one cycle per operation.
  a_busy_one: assert property (@(posedge clk) disable iff (rst)
    busy |=> (!busy && done))
    else $error("busy did not end with a result");

  // A strobe only follows a busy cycle.
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without an operation");

  // A dropped push reports a full stack.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (entries_left == LEFT_W'(STACK_DEPTH)))
    else $error("full status with a stack that is not full");

  // A miss returns no record.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_MISS) |->
      (out_id == '0 && out_age == '0 && out_name_ref == '0))
    else $error("record data on a miss");

endmodule

bind record_stack_with_keyed_extract_unit rsk_check u_rsk_check (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .status       (status),
  .out_id       (out_id),
  .out_age      (out_age),
  .out_name_ref (out_name_ref),
  .entries_left (entries_left)
);

// ===== sim/rsk_reply_checker.sv =====
// ----------------------------------------------------------------------------
// rsk_reply_checker
// Watches the command and reply ports of the record stack, predicts every
// reply from its own copy of the stack contents and compares field by field.
// ----------------------------------------------------------------------------
module rsk_reply_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic [1:0]                 opcode,
  input  logic [rsk_pkg::ID_W-1:0]   key_id,
  input  logic [rsk_pkg::AGE_W-1:0]  record_age,
  input  logic [rsk_pkg::NAME_W-1:0] record_name_ref,
  input  logic                       done,
  input  logic [1:0]                 status,
  input  logic [rsk_pkg::ID_W-1:0]   out_id,
  input  logic [rsk_pkg::AGE_W-1:0]  out_age,
  input  logic [rsk_pkg::NAME_W-1:0] out_name_ref,
  input  logic [rsk_pkg::LEFT_W-1:0] entries_left,
  output int                         failures,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rsk_pkg::*;

  // One predicted reply of the stack.
  typedef struct {
    status_t           status;
    logic [ID_W-1:0]   id;
    logic [AGE_W-1:0]  age;
    logic [NAME_W-1:0] name_ref;
    logic [LEFT_W-1:0] left;
  } stack_reply_t;

  // Predicted replies still waiting for the done strobe, oldest first.
  stack_reply_t stack_replies[$];

  // Shadow copy of the stack: cell 0 is the bottom, cell fill-1 the top.
  logic [ID_W-1:0]   cell_id   [STACK_DEPTH];
  logic [AGE_W-1:0]  cell_age  [STACK_DEPTH];
  logic [NAME_W-1:0] cell_name [STACK_DEPTH];
  int                fill;

  // Applies one operation to the shadow stack and returns its reply.
  function automatic stack_reply_t apply_stack_op(input op_t op,
                                                  input logic [ID_W-1:0] key,
                                                  input logic [AGE_W-1:0] age,
                                                  input logic [NAME_W-1:0] name_ref);
    stack_reply_t r;
    int           hit;
    r.status   = ST_MISS;
    r.id       = '0;
    r.age      = '0;
    r.name_ref = '0;
    hit        = -1;
    case (op)
      OP_PUSH: begin
        if (fill >= STACK_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          cell_id[fill]   = key;
          cell_age[fill]  = age;
          cell_name[fill] = name_ref;
          fill++;
          r.status = ST_OK;
        end
      end
      OP_POP: begin
        if (fill > 0) begin
          fill--;
          r.id       = cell_id[fill];
          r.age      = cell_age[fill];
          r.name_ref = cell_name[fill];
          r.status   = ST_OK;
        end
      end
      OP_FIND: begin
        // The match nearest the top wins.
        for (int i = fill - 1; i >= 0; i--) begin
          if (hit < 0 && cell_id[i] == key) hit = i;
        end
        if (hit >= 0) begin
          r.id       = cell_id[hit];
          r.age      = cell_age[hit];
          r.name_ref = cell_name[hit];
          r.status   = ST_OK;
          // Close the gap so the other records keep their order.
          for (int k = hit; k < fill - 1; k++) begin
            cell_id[k]   = cell_id[k + 1];
            cell_age[k]  = cell_age[k + 1];
            cell_name[k] = cell_name[k + 1];
          end
          fill--;
        end
      end
      default: ;
    endcase
    r.left = LEFT_W'(fill);
    return r;
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    failures++;
  endtask

  // Replies are compared before a transfer in the same cycle is predicted,
  // since a reply always belongs to an earlier transfer.
  always @(posedge clk) begin : watch_channels
    stack_reply_t want;
    if (rst) begin
      stack_replies.delete();
      fill     = 0;
      failures = 0;
    end else begin
      if (done) begin
        if (stack_replies.size() == 0) begin
          report_mismatch($sformatf("reply with nothing outstanding, status %0d id 0x%0h",
                                    status, out_id));
        end else begin
          want = stack_replies.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("status expected %0d got %0d", want.status, status));
          if (out_id !== want.id)
            report_mismatch($sformatf("out_id expected 0x%0h got 0x%0h", want.id, out_id));
          if (out_age !== want.age)
            report_mismatch($sformatf("out_age expected 0x%0h got 0x%0h", want.age, out_age));
          if (out_name_ref !== want.name_ref)
            report_mismatch($sformatf("out_name_ref expected 0x%0h got 0x%0h",
                                      want.name_ref, out_name_ref));
          if (entries_left !== want.left)
            report_mismatch($sformatf("entries_left expected %0d got %0d",
                                      want.left, entries_left));
        end
      end
      if (start && !busy)
        stack_replies.push_back(apply_stack_op(op_t'(opcode), key_id, record_age,
                                               record_name_ref));
    end
    pending <= stack_replies.size();
  end

endmodule

// ===== sim/record_stack_with_keyed_extract_unit_tb.sv =====
// ----------------------------------------------------------------------------
// record_stack_with_keyed_extract_unit_tb
// Drives push, pop and find-and-remove commands into the record stack, first
// a directed set of corner cases, then random traffic with idle gaps, and
// gives the verdict from the failure and pending counts of the reply checker.
// ----------------------------------------------------------------------------
module record_stack_with_keyed_extract_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rsk_pkg::*;

  localparam int N_RANDOM       = 600;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int END_WAIT_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        opcode;
  logic [ID_W-1:0]   key_id;
  logic [AGE_W-1:0]  record_age;
  logic [NAME_W-1:0] record_name_ref;
  logic              done;
  logic [1:0]        status;
  logic [ID_W-1:0]   out_id;
  logic [AGE_W-1:0]  out_age;
  logic [NAME_W-1:0] out_name_ref;
  logic [LEFT_W-1:0] entries_left;
  int                failures;
  int                pending;
  int                cycle_count = 0;

  record_stack_with_keyed_extract_unit u_top (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .opcode          (opcode),
    .key_id          (key_id),
    .record_age      (record_age),
    .record_name_ref (record_name_ref),
    .done            (done),
    .status          (status),
    .out_id          (out_id),
    .out_age         (out_age),
    .out_name_ref    (out_name_ref),
    .entries_left    (entries_left)
  );

  rsk_reply_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .opcode          (opcode),
    .key_id          (key_id),
    .record_age      (record_age),
    .record_name_ref (record_name_ref),
    .done            (done),
    .status          (status),
    .out_id          (out_id),
    .out_age         (out_age),
    .out_name_ref    (out_name_ref),
    .entries_left    (entries_left),
    .failures        (failures),
    .pending         (pending)
  );

  // Clock with a 12 ns period.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Keys mostly come from a small pool so that finds hit and ids repeat.
  function automatic logic [ID_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return ID_W'($urandom_range(0, 11));
    if (roll < 80) return {{(ID_W - 4){1'b1}}, 4'($urandom_range(0, 15))};
    return ID_W'($urandom);
  endfunction

  // Presents one command and holds it until the transfer takes place.
  task automatic issue_op(input op_t op, input logic [ID_W-1:0] key,
                          input logic [AGE_W-1:0] age, input logic [NAME_W-1:0] name_ref);
    @(negedge clk);
    start           <= 1'b1;
    opcode          <= op;
    key_id          <= key;
    record_age      <= age;
    record_name_ref <= name_ref;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Idles the command port with junk on the fields.
  task automatic idle_for(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start           <= 1'b0;
      opcode          <= 2'($urandom);
      key_id          <= ID_W'($urandom);
      record_age      <= AGE_W'($urandom);
      record_name_ref <= $urandom;
    end
  endtask

  // Holds off new commands until every outstanding reply has come back.
  task automatic hold_until_drained();
    idle_for(1);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int   push_pct;
    int   roll;
    int   wait_cycles;
    op_t  op;
    logic quiet;

    rst             = 1'b1;
    start           = 1'b0;
    opcode          = OP_PUSH;
    key_id          = '0;
    record_age      = '0;
    record_name_ref = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty stack, unused opcode, field extremes, duplicate ids,
    // removal from the middle, a miss, then fill to full and overflow.
    issue_op(OP_POP,  '0, '0, '0);
    issue_op(OP_FIND, '0, '0, '0);
    issue_op(OP_NONE, ID_W'($urandom), AGE_W'($urandom), $urandom);
    issue_op(OP_PUSH, '0, '0, '0);
    issue_op(OP_PUSH, '1, '1, '1);
    issue_op(OP_PUSH, 31'd5, 8'd1, 32'h0000_000a);
    issue_op(OP_PUSH, 31'd5, 8'd2, 32'h0000_000b);
    issue_op(OP_FIND, 31'd5, '0, '0);
    issue_op(OP_FIND, '1, '0, '0);
    issue_op(OP_FIND, 31'd123, '0, '0);
    issue_op(OP_NONE, 31'd5, '1, '1);
    issue_op(OP_POP,  '0, '0, '0);
    for (int i = 1; i < STACK_DEPTH; i++)
      issue_op(OP_PUSH, ID_W'(100 + 3 * i), AGE_W'(i), $urandom);
    issue_op(OP_PUSH, 31'd77, 8'd77, 32'h0000_0077);
    issue_op(OP_FIND, '0, '0, '0);

    // Random traffic: phases lean toward filling, draining or balance.
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 150 || n == 450) hold_until_drained();
      quiet = (n >= 250 && n < 350);
      if (!quiet && $urandom_range(0, 99) < 27) idle_for($urandom_range(1, 4));
      case ((n / 60) % 3)
        0:       push_pct = 55;
        1:       push_pct = 25;
        default: push_pct = 40;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 3)                                 op = OP_NONE;
      else if (roll < 3 + push_pct)                 op = OP_PUSH;
      else if (roll < 3 + push_pct + (97 - push_pct) / 2) op = OP_POP;
      else                                          op = OP_FIND;
      issue_op(op, pick_key(), AGE_W'($urandom), $urandom);
    end

    // Drain, then wait out the settle period for any stray strobe.
    idle_for(1);
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < END_WAIT_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
